@@ hdl/pfi_pkg.sv @@
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared types, fixed-point formats and calibration tables for the
// pressure-to-flow interpolator.
// ----------------------------------------------------------------------------
package pfi_pkg;

    localparam int TABLE_POINTS  = 6;
    localparam int FRACTION_BITS = 8;

    localparam int CAL_POINTS = 6;
    localparam int MAX_POINTS = 16;
    localparam int SLOPE_BITS = 16;

    // Points actually used: the clamped table size, never more than the calibration set.
    localparam int NPTS = (TABLE_POINTS < 2) ? 2 :
                          ((TABLE_POINTS > MAX_POINTS) ? MAX_POINTS : TABLE_POINTS);
    localparam int NUSE = (NPTS < CAL_POINTS) ? NPTS : CAL_POINTS;

    // Breakpoint pressures stay below 128 cmH2O and flows below 256 L/min.
    localparam int PT_W   = 7 + FRACTION_BITS;
    localparam int FL_W   = 8 + FRACTION_BITS;
    localparam int SL_W   = 20;
    localparam int CMP_W  = 17 + FRACTION_BITS;
    localparam int PROD_W = PT_W + SL_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam int PRESSURE_W = 16;
    localparam int FLOW_W     = 16;

    typedef enum logic [1:0] {
        PATIENT_ADULT     = 2'd0,
        PATIENT_PEDIATRIC = 2'd1,
        PATIENT_NEONATAL  = 2'd2,
        PATIENT_INVALID   = 2'd3
    } patient_t;

    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_BAD_PARAM = 1'b1
    } status_t;

    typedef struct packed {
        logic [1:0]                   patient_type;
        logic signed [PRESSURE_W-1:0] pressure;
    } sample_word_t;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic              status;
    } result_word_t;

    // Segment chosen for one sample, handed from the selector to the evaluator.
    typedef struct packed {
        logic [FL_W-1:0] f0;
        logic [SL_W-1:0] slope;
        logic [PT_W-1:0] off;
        logic            error;
    } seg_t;

    // Calibration: pressure in hundredths of a cmH2O, flow in tenths of a L/min.
    localparam int unsigned ADULT_P_RAW [CAL_POINTS] = '{107, 514, 1139, 2456, 3898, 4934};
    localparam int unsigned ADULT_F_RAW [CAL_POINTS] = '{104, 395, 606, 905, 1173, 1338};
    localparam int unsigned NEO_P_RAW   [CAL_POINTS] = '{342, 561, 1008, 2126, 5134, 7675};
    localparam int unsigned NEO_F_RAW   [CAL_POINTS] = '{11, 64, 141, 262, 466, 569};

    function automatic int unsigned fix_hundredths(input int unsigned v);
        return ((v << FRACTION_BITS) + 32'd50) / 32'd100;
    endfunction

    function automatic int unsigned fix_tenths(input int unsigned v);
        return ((v << FRACTION_BITS) + 32'd5) / 32'd10;
    endfunction

    localparam int unsigned ADULT_PT [CAL_POINTS] = '{
        fix_hundredths(ADULT_P_RAW[0]), fix_hundredths(ADULT_P_RAW[1]),
        fix_hundredths(ADULT_P_RAW[2]), fix_hundredths(ADULT_P_RAW[3]),
        fix_hundredths(ADULT_P_RAW[4]), fix_hundredths(ADULT_P_RAW[5])};
    localparam int unsigned ADULT_FT [CAL_POINTS] = '{
        fix_tenths(ADULT_F_RAW[0]), fix_tenths(ADULT_F_RAW[1]),
        fix_tenths(ADULT_F_RAW[2]), fix_tenths(ADULT_F_RAW[3]),
        fix_tenths(ADULT_F_RAW[4]), fix_tenths(ADULT_F_RAW[5])};
    localparam int unsigned NEO_PT [CAL_POINTS] = '{
        fix_hundredths(NEO_P_RAW[0]), fix_hundredths(NEO_P_RAW[1]),
        fix_hundredths(NEO_P_RAW[2]), fix_hundredths(NEO_P_RAW[3]),
        fix_hundredths(NEO_P_RAW[4]), fix_hundredths(NEO_P_RAW[5])};
    localparam int unsigned NEO_FT [CAL_POINTS] = '{
        fix_tenths(NEO_F_RAW[0]), fix_tenths(NEO_F_RAW[1]),
        fix_tenths(NEO_F_RAW[2]), fix_tenths(NEO_F_RAW[3]),
        fix_tenths(NEO_F_RAW[4]), fix_tenths(NEO_F_RAW[5])};

    // Segment slopes in Q16 flow units per pressure unit, rounded half up.
    localparam longint ADULT_SLOPE [CAL_POINTS-1] = '{
        ((longint'(ADULT_FT[1] - ADULT_FT[0]) << SLOPE_BITS) + (ADULT_PT[1] - ADULT_PT[0]) / 2)
            / longint'(ADULT_PT[1] - ADULT_PT[0]),
        ((longint'(ADULT_FT[2] - ADULT_FT[1]) << SLOPE_BITS) + (ADULT_PT[2] - ADULT_PT[1]) / 2)
            / longint'(ADULT_PT[2] - ADULT_PT[1]),
        ((longint'(ADULT_FT[3] - ADULT_FT[2]) << SLOPE_BITS) + (ADULT_PT[3] - ADULT_PT[2]) / 2)
            / longint'(ADULT_PT[3] - ADULT_PT[2]),
        ((longint'(ADULT_FT[4] - ADULT_FT[3]) << SLOPE_BITS) + (ADULT_PT[4] - ADULT_PT[3]) / 2)
            / longint'(ADULT_PT[4] - ADULT_PT[3]),
        ((longint'(ADULT_FT[5] - ADULT_FT[4]) << SLOPE_BITS) + (ADULT_PT[5] - ADULT_PT[4]) / 2)
            / longint'(ADULT_PT[5] - ADULT_PT[4])};
    localparam longint NEO_SLOPE [CAL_POINTS-1] = '{
        ((longint'(NEO_FT[1] - NEO_FT[0]) << SLOPE_BITS) + (NEO_PT[1] - NEO_PT[0]) / 2)
            / longint'(NEO_PT[1] - NEO_PT[0]),
        ((longint'(NEO_FT[2] - NEO_FT[1]) << SLOPE_BITS) + (NEO_PT[2] - NEO_PT[1]) / 2)
            / longint'(NEO_PT[2] - NEO_PT[1]),
        ((longint'(NEO_FT[3] - NEO_FT[2]) << SLOPE_BITS) + (NEO_PT[3] - NEO_PT[2]) / 2)
            / longint'(NEO_PT[3] - NEO_PT[2]),
        ((longint'(NEO_FT[4] - NEO_FT[3]) << SLOPE_BITS) + (NEO_PT[4] - NEO_PT[3]) / 2)
            / longint'(NEO_PT[4] - NEO_PT[3]),
        ((longint'(NEO_FT[5] - NEO_FT[4]) << SLOPE_BITS) + (NEO_PT[5] - NEO_PT[4]) / 2)
            / longint'(NEO_PT[5] - NEO_PT[4])};

endpackage

@@ hdl/pfi_segment_select.sv @@
// ----------------------------------------------------------------------------
// pfi_segment_select
// Compares one pressure against every breakpoint of the chosen table in
// parallel and returns the start flow, slope and offset of its segment.
// ----------------------------------------------------------------------------
module pfi_segment_select (
    input  pfi_pkg::sample_word_t sample_word,
    output pfi_pkg::seg_t         seg
);
    import pfi_pkg::*;

    logic                    neo;
    logic signed [CMP_W-1:0] p_ext;
    logic signed [CMP_W-1:0] bp    [CAL_POINTS];
    logic [FL_W-1:0]         fl    [CAL_POINTS];
    logic [SL_W-1:0]         sl    [CAL_POINTS-1];
    logic [PT_W-1:0]         offs  [CAL_POINTS-1];

    assign neo   = (sample_word.patient_type == PATIENT_NEONATAL);
    assign p_ext = CMP_W'(sample_word.pressure);

    always_comb
    begin
        for (int i = 0; i < CAL_POINTS; i++)
        begin
            bp[i] = neo ? CMP_W'(PT_W'(NEO_PT[i])) : CMP_W'(PT_W'(ADULT_PT[i]));
            fl[i] = neo ? FL_W'(NEO_FT[i]) : FL_W'(ADULT_FT[i]);
        end
        for (int i = 0; i < CAL_POINTS - 1; i++)
        begin
            sl[i]   = neo ? SL_W'(NEO_SLOPE[i]) : SL_W'(ADULT_SLOPE[i]);
            offs[i] = PT_W'(p_ext - bp[i]);
        end
    end

    always_comb
    begin
        // Above the last breakpoint the flow holds at the last table value.
        seg.f0    = fl[NUSE-1];
        seg.slope = '0;
        seg.off   = '0;
        seg.error = 1'b0;
        // Walk down so that the lowest breakpoint at or above the pressure wins.
        for (int i = NUSE - 1; i >= 1; i--)
        begin
            if (p_ext <= bp[i])
            begin
                seg.f0    = fl[i-1];
                seg.slope = sl[i-1];
                seg.off   = offs[i-1];
            end
        end
        if (p_ext <= bp[0])
        begin
            seg.f0    = fl[0];
            seg.slope = '0;
            seg.off   = '0;
        end
        if (sample_word.patient_type == PATIENT_INVALID)
        begin
            seg.f0    = '0;
            seg.slope = '0;
            seg.off   = '0;
            seg.error = 1'b1;
        end
    end

endmodule

@@ hdl/pfi_segment_eval.sv @@
// ----------------------------------------------------------------------------
// pfi_segment_eval
// Evaluates the selected segment: one multiply, a rounding shift, the add of
// the start flow, saturation to the output width, or zero flow on error.
// ----------------------------------------------------------------------------
module pfi_segment_eval (
    input  pfi_pkg::seg_t        seg,
    output pfi_pkg::result_word_t result_word
);
    import pfi_pkg::*;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SLOPE_BITS - 1);
    localparam logic [SUM_W-1:0] FLOW_MAX   = SUM_W'({FLOW_W{1'b1}});

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  rounded;
    logic [SUM_W-1:0]  sum;

    assign prod    = PROD_W'(seg.off) * PROD_W'(seg.slope);
    assign rounded = (SUM_W'(prod) + ROUND_HALF) >> SLOPE_BITS;
    assign sum     = rounded + SUM_W'(seg.f0);

    always_comb
    begin
        if (seg.error)
        begin
            result_word.flow   = '0;
            result_word.status = STATUS_BAD_PARAM;
        end
        else
        begin
            result_word.flow   = (sum > FLOW_MAX) ? {FLOW_W{1'b1}} : sum[FLOW_W-1:0];
            result_word.status = STATUS_OK;
        end
    end

endmodule

@@ hdl/pressure_to_flow_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// pressure_to_flow_interpolator_top
// Converts pressure samples to flow through a piecewise linear calibration.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock and returns one result word per
// sample, in order, via the sample register and then the result register.
// Throughput is one sample per cycle while the result side is ready, set by
// the single pass from the sample register through the parallel breakpoint
// compares and the one segment multiply into the result register. A stalled
// result holds in the result register while the sample register still takes
// one more word, and the sample side only backs up when both are full.
module pressure_to_flow_interpolator_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  pfi_pkg::sample_word_t sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pfi_pkg::result_word_t result
);
    import pfi_pkg::*;

    logic         in_valid_reg;
    sample_word_t in_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;
    logic         advance;
    seg_t         seg;
    result_word_t result_next;

    assign advance      = !out_valid_reg || result_ready;
    assign sample_ready = !in_valid_reg || advance;

    pfi_segment_select u_select (
        .sample_word (in_word_reg),
        .seg         (seg)
    );

    pfi_segment_eval u_eval (
        .seg         (seg),
        .result_word (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_word_reg <= sample;
        end
        if (advance && in_valid_reg)
        begin
            out_word_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

@@ hdl/pfi_checker.sv @@
// ----------------------------------------------------------------------------
// pfi_checker
// Port-level checks for the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module pfi_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sample_valid,
    input logic                  sample_ready,
    input pfi_pkg::sample_word_t sample,
    input logic                  result_valid,
    input logic                  result_ready,
    input pfi_pkg::result_word_t result
);
    import pfi_pkg::*;

    // An error result never carries a flow.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == STATUS_BAD_PARAM) |-> (result.flow == '0))
        else $error("error result with nonzero flow");

    // A stalled result holds its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // With the result side empty, the block always takes a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("sample refused while result side empty");

    // A fresh result stems from an accepted sample that passed through the sample register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
        else $error("result without matching sample");

    // An invalid patient type taken by an idle block reports an error in its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && !result_valid &&
        (sample.patient_type == PATIENT_INVALID) |=>
        ##1 (!result_valid || (result.status == STATUS_BAD_PARAM)) || $past(result_valid))
        else $error("invalid patient type not reported");

endmodule

bind pressure_to_flow_interpolator_top pfi_checker u_pfi_checker (.*);
